// ===== sv/sshm_pkg.sv =====
// ----------------------------------------------------------------------------
// sshm_pkg
// Types, codes and widths shared by the severity score monitor modules.
// ----------------------------------------------------------------------------
package sshm_pkg;

    localparam int PEAK_W  = 24;
    localparam int REF_W   = 24;
    localparam int DEC_W   = 16;
    localparam int SCORE_W = 32;
    localparam int ERR_W   = 16;
    localparam int FRAC_W  = 16;
    localparam int QUO_W   = PEAK_W + FRAC_W;
    localparam int PROD_W  = DEC_W + SCORE_W;
    localparam int SUM_W   = QUO_W + 1;
    localparam int CNT_W   = $clog2(QUO_W);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [QUO_W-1:0] ONE_Q16 = QUO_W'(1) << FRAC_W;

    localparam logic [1:0] COND_NORMAL  = 2'd0;
    localparam logic [1:0] COND_WARNING = 2'd1;
    localparam logic [1:0] COND_ALARM   = 2'd2;
    localparam logic [1:0] COND_FAULT   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_IMPACT_REFERENCE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAK_GAIN           = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WARNING_ENTER_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WARNING_EXIT_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_ENTER_LEVEL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_EXIT_LEVEL    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_CEILING       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_ERROR_LIMIT   = 3'd7;

    typedef struct packed {
        logic               mode;
        logic [ERR_W-1:0]   sensor_error_run;
        logic               window_ready;
        logic [PEAK_W-1:0]  peak_magnitude;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         condition;
        logic [SCORE_W-1:0] score_out;
    } out_item_t;

    typedef struct packed {
        logic [REF_W-1:0]   impact_reference;
        logic [DEC_W-1:0]   leak_gain;
        logic [SCORE_W-1:0] warning_enter_level;
        logic [SCORE_W-1:0] warning_exit_level;
        logic [SCORE_W-1:0] alarm_enter_level;
        logic [SCORE_W-1:0] alarm_exit_level;
        logic [SCORE_W-1:0] score_ceiling;
        logic [ERR_W-1:0]   fault_error_limit;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic contrib;
        logic sat;
        logic cond;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic window;
        logic out_free;
    } ctrl_status_t;

    function automatic logic [1:0] next_condition(
        input logic [1:0]         cur,
        input logic [SCORE_W-1:0] s,
        input cfg_t               cfg
    );
        logic [1:0] nxt;
        nxt = cur;
        case (cur)
            COND_NORMAL:
            begin
                if (s >= cfg.alarm_enter_level)
                    nxt = COND_ALARM;
                else if (s >= cfg.warning_enter_level)
                    nxt = COND_WARNING;
                else
                    nxt = COND_NORMAL;
            end
            COND_WARNING:
            begin
                if (s >= cfg.alarm_enter_level)
                    nxt = COND_ALARM;
                else if (s <= cfg.warning_exit_level)
                    nxt = COND_NORMAL;
                else
                    nxt = COND_WARNING;
            end
            COND_ALARM:
            begin
                if (s <= cfg.alarm_exit_level)
                    nxt = COND_WARNING;
                else
                    nxt = COND_ALARM;
            end
            default:
            begin
                nxt = COND_FAULT;
            end
        endcase
        return nxt;
    endfunction

endpackage

// ===== sv/sshm_ctrl.sv =====
// ----------------------------------------------------------------------------
// sshm_ctrl
// Sequencer: accept a transfer, step the divider, form the contribution,
// saturate, update the condition and hand the result to the output register.
// ----------------------------------------------------------------------------
module sshm_ctrl
    import sshm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DIV     = 3'd1;
    localparam logic [2:0] S_CONTRIB = 3'd2;
    localparam logic [2:0] S_SAT     = 3'd3;
    localparam logic [2:0] S_COND    = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    cnt_next   = '0;
                    state_next = status.window ? S_DIV : S_DONE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_STEP)
                    state_next = S_CONTRIB;
            end
            S_CONTRIB:
            begin
                cmd.contrib = 1'b1;
                state_next  = S_SAT;
            end
            S_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = S_COND;
            end
            S_COND:
            begin
                cmd.cond   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == LAST_STEP) |=> (state_reg == S_CONTRIB))
        else $error("divider did not finish after the full step count");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over an untaken transfer");

endmodule

// ===== sv/sshm_dp.sv =====
// ----------------------------------------------------------------------------
// sshm_dp
// Datapath: serial restoring divider, decay multiplier, saturating add,
// hysteresis state and the output register.
// ----------------------------------------------------------------------------
module sshm_dp
    import sshm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  in_item_t     in_data,
    input  logic         out_stall,
    input  ctrl_cmd_t    cmd,
    output ctrl_status_t status,
    output logic         out_valid,
    output out_item_t    out_data
);

    logic [1:0]         condition_reg;
    logic [SCORE_W-1:0] severity_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [REF_W-1:0]   rem_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [QUO_W-1:0]   contrib_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic               is_clear;
    logic               is_fault;
    logic [REF_W:0]     rem_shift;
    logic               q_bit;
    logic [REF_W:0]     rem_diff;
    logic [SUM_W-1:0]   total;
    logic [SCORE_W-1:0] decayed;

    assign is_clear = in_data.mode;
    assign is_fault = !in_data.mode && (in_data.sensor_error_run >= cfg.fault_error_limit);

    assign status.window   = !is_clear && !is_fault && (condition_reg != COND_FAULT)
                             && in_data.window_ready;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign rem_shift = {rem_reg, quo_reg[QUO_W-1]};
    assign rem_diff  = rem_shift - {1'b0, cfg.impact_reference};
    assign q_bit     = (rem_shift >= {1'b0, cfg.impact_reference});

    assign decayed = prod_reg[PROD_W-1:FRAC_W];
    assign total   = SUM_W'(decayed) + SUM_W'(contrib_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            quo_reg <= {in_data.peak_magnitude, FRAC_W'(0)};
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[QUO_W-2:0], q_bit};
            rem_reg <= q_bit ? rem_diff[REF_W-1:0] : rem_shift[REF_W-1:0];
        end
        if (cmd.div_step)
            prod_reg <= cfg.leak_gain * severity_reg;
        if (cmd.contrib)
            contrib_reg <= (quo_reg > ONE_Q16) ? (quo_reg - ONE_Q16) : '0;
        if (cmd.out_load)
            out_data_reg <= '{condition: condition_reg, score_out: severity_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            condition_reg <= COND_NORMAL;
            severity_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept && is_clear)
            begin
                condition_reg <= COND_NORMAL;
                severity_reg  <= '0;
            end
            else if (cmd.accept && is_fault)
            begin
                condition_reg <= COND_FAULT;
            end
            if (cmd.sat)
            begin
                if (total > SUM_W'(cfg.score_ceiling))
                    severity_reg <= cfg.score_ceiling;
                else
                    severity_reg <= total[SCORE_W-1:0];
            end
            if (cmd.cond)
                condition_reg <= next_condition(condition_reg, severity_reg, cfg);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && is_clear) |=> (severity_reg == '0 && condition_reg == COND_NORMAL))
        else $error("clear did not return to normal with zero score");

    a_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && is_fault) |=> (condition_reg == COND_FAULT))
        else $error("error run at limit did not latch sensor fault");

    a_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sat |=> (severity_reg <= cfg.score_ceiling))
        else $error("score above ceiling after saturation");

endmodule

// ===== sv/severity_score_hysteresis_monitor.sv =====
// ----------------------------------------------------------------------------
// severity_score_hysteresis_monitor
// Leaky severity score with a four-state hysteresis condition. One result per
// transfer. A clear, a sensor fault or an update without a window goes from
// accept to the done state; an update with a window runs the 40-step serial
// divider (peak / reference, one quotient bit per cycle), then contribution,
// saturation and condition. A new transfer is accepted once the previous
// result sits in the output register, which holds it until taken.
// ----------------------------------------------------------------------------
module severity_score_hysteresis_monitor
    import sshm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data
);

    cfg_t         cfg_reg;
    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.impact_reference    <= REF_W'(4096);
            cfg_reg.leak_gain           <= DEC_W'(58982);
            cfg_reg.warning_enter_level <= SCORE_W'(65536);
            cfg_reg.warning_exit_level  <= SCORE_W'(32768);
            cfg_reg.alarm_enter_level   <= SCORE_W'(196608);
            cfg_reg.alarm_exit_level    <= SCORE_W'(131072);
            cfg_reg.score_ceiling       <= SCORE_W'(327680);
            cfg_reg.fault_error_limit   <= ERR_W'(3);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMPACT_REFERENCE:    cfg_reg.impact_reference    <= cfg_wdata[REF_W-1:0];
                REG_LEAK_GAIN:           cfg_reg.leak_gain           <= cfg_wdata[DEC_W-1:0];
                REG_WARNING_ENTER_LEVEL: cfg_reg.warning_enter_level <= cfg_wdata[SCORE_W-1:0];
                REG_WARNING_EXIT_LEVEL:  cfg_reg.warning_exit_level  <= cfg_wdata[SCORE_W-1:0];
                REG_ALARM_ENTER_LEVEL:   cfg_reg.alarm_enter_level   <= cfg_wdata[SCORE_W-1:0];
                REG_ALARM_EXIT_LEVEL:    cfg_reg.alarm_exit_level    <= cfg_wdata[SCORE_W-1:0];
                REG_SCORE_CEILING:       cfg_reg.score_ceiling       <= cfg_wdata[SCORE_W-1:0];
                REG_FAULT_ERROR_LIMIT:   cfg_reg.fault_error_limit   <= cfg_wdata[ERR_W-1:0];
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    sshm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sshm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_data   (in_data),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
